### hdl/itp_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Integer text parser package
// Shared types and fixed constants for the integer text parser blocks.
// ============================================================================
package itp_pkg;

    localparam int CHAR_BITS       = 8;
    localparam int BASE_BITS       = 5;
    localparam int OFFSET_BITS     = 16;
    localparam int OFFSET_EXT_BITS = 32;
    localparam int CFG_IDX_BITS    = 2;
    localparam int CFG_DATA_BITS   = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_RADIX         = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SIGN_ENABLE   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SUFFIX_ENABLE = 2'd2;

    typedef enum logic [2:0] {
        PH_START,
        PH_PREFIX,
        PH_ZERO,
        PH_DIGITS,
        PH_SUF_I,
        PH_SUF_B,
        PH_TAIL
    } t_phase;

    typedef struct packed {
        logic [BASE_BITS-1:0] radix;
        logic                 sign_enable;
        logic                 suffix_enable;
    } t_cfg;

    typedef struct packed {
        logic                 valid;
        logic [CHAR_BITS-1:0] chr;
    } t_char_word;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] end_offset;
        logic                   strict_ok;
        logic                   digits_seen;
    } t_result_meta;

endpackage

### hdl/itp_char_if.sv
`timescale 1ns / 1ps
// ============================================================================
// Character channel
// Carries one character of the text string per word.
// ============================================================================
interface itp_char_if;
    logic                           valid;
    logic                           ready;
    logic [itp_pkg::CHAR_BITS-1:0]  char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

### hdl/itp_result_if.sv
`timescale 1ns / 1ps
// ============================================================================
// Result channel
// Carries one parse result per terminated string.
// ============================================================================
interface itp_result_if #(
    parameter int VALUE_BITS = 64
);
    logic                             valid;
    logic                             ready;
    logic [VALUE_BITS-1:0]            value;
    logic [itp_pkg::OFFSET_BITS-1:0]  end_offset;
    logic                             strict_ok;
    logic                             digits_seen;

    modport source (output valid, output value, output end_offset, output strict_ok,
                    output digits_seen, input ready);
    modport sink   (input valid, input value, input end_offset, input strict_ok,
                    input digits_seen, output ready);
endinterface

### hdl/itp_cfg_if.sv
`timescale 1ns / 1ps
// ============================================================================
// Configuration write channel
// Carries a register index and the data to be written to it.
// ============================================================================
interface itp_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [itp_pkg::CFG_IDX_BITS-1:0]   index;
    logic [itp_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/itp_char_stage.sv
`timescale 1ns / 1ps
// ============================================================================
// Character input register
// Holds one accepted character until the parse core takes it.
// ============================================================================
module itp_char_stage (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [itp_pkg::CHAR_BITS-1:0]  i_char,
    output logic                           o_ready,
    input  logic                           i_take,
    output itp_pkg::t_char_word            o_word
);

    logic                          r_valid;
    logic [itp_pkg::CHAR_BITS-1:0] r_char;

    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_char <= i_char;
        end
    end

    assign o_word.valid = r_valid;
    assign o_word.chr   = r_char;

endmodule

### hdl/itp_parse_core.sv
`timescale 1ns / 1ps
// ============================================================================
// Parse core
// Per-string parse state and the combinational update for one character.
// ============================================================================
module itp_parse_core #(
    parameter int VALUE_BITS = 64,
    parameter int LEN_BITS   = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  itp_pkg::t_cfg               i_cfg,
    input  itp_pkg::t_char_word         i_word,
    input  logic                        i_res_room,
    output logic                        o_take,
    output logic                        o_res_load,
    output logic [VALUE_BITS-1:0]       o_res_value,
    output itp_pkg::t_result_meta       o_res_meta
);

    localparam int PROD_BITS = VALUE_BITS + itp_pkg::BASE_BITS;
    localparam int SUM_BITS  = LEN_BITS + 1;

    localparam logic [itp_pkg::CHAR_BITS-1:0] CH_NUL     = 8'h00;
    localparam logic [itp_pkg::CHAR_BITS-1:0] CH_NL      = 8'h0a;
    localparam logic [itp_pkg::CHAR_BITS-1:0] CH_MINUS   = 8'h2d;
    localparam logic [itp_pkg::CHAR_BITS-1:0] CH_ZERO    = 8'h30;
    localparam logic [itp_pkg::CHAR_BITS-1:0] CH_NINE    = 8'h39;
    localparam logic [itp_pkg::CHAR_BITS-1:0] CH_LO_A    = 8'h61;
    localparam logic [itp_pkg::CHAR_BITS-1:0] CH_LO_F    = 8'h66;
    localparam logic [itp_pkg::CHAR_BITS-1:0] CH_LO_G    = 8'h67;
    localparam logic [itp_pkg::CHAR_BITS-1:0] CH_LO_I    = 8'h69;
    localparam logic [itp_pkg::CHAR_BITS-1:0] CH_LO_K    = 8'h6b;
    localparam logic [itp_pkg::CHAR_BITS-1:0] CH_LO_M    = 8'h6d;
    localparam logic [itp_pkg::CHAR_BITS-1:0] CH_LO_X    = 8'h78;
    localparam logic [itp_pkg::CHAR_BITS-1:0] CH_UP_B    = 8'h42;
    localparam logic [itp_pkg::CHAR_BITS-1:0] CASE_BIT   = 8'h20;

    localparam logic [itp_pkg::BASE_BITS-1:0] BASE_OCT   = 5'd8;
    localparam logic [itp_pkg::BASE_BITS-1:0] BASE_DEC   = 5'd10;
    localparam logic [itp_pkg::BASE_BITS-1:0] BASE_HEX   = 5'd16;

    localparam int SHIFT_K = 10;
    localparam int SHIFT_M = 20;
    localparam int SHIFT_G = 30;

    itp_pkg::t_phase                 r_phase, n_phase;
    logic [VALUE_BITS-1:0]           r_accum, n_accum;
    logic [itp_pkg::BASE_BITS-1:0]   r_base, n_base;
    logic [LEN_BITS-1:0]             r_consumed, n_consumed;
    logic                            r_negate, n_negate;
    logic                            r_digit_flag, n_digit_flag;
    logic [1:0]                      r_tail_cnt, n_tail_cnt;
    logic                            r_tail_nl, n_tail_nl;

    logic [itp_pkg::CHAR_BITS-1:0]   w_chr;
    logic [itp_pkg::CHAR_BITS-1:0]   w_lc;
    logic                            w_is_nul;
    logic                            w_hex_ok;
    logic [3:0]                      w_hex_val;
    logic [itp_pkg::BASE_BITS-1:0]   w_dig_base;
    logic                            w_dig_ok;
    logic [PROD_BITS-1:0]            w_prod;
    logic [VALUE_BITS-1:0]           w_mac;
    logic                            w_suffix_hit;
    logic [VALUE_BITS-1:0]           w_shifted;
    logic                            w_digit_step;
    logic                            w_tail_step;
    logic [1:0]                      w_take_cnt;
    logic [SUM_BITS-1:0]             w_sum;
    logic [LEN_BITS-1:0]             w_consumed_sat;
    logic [itp_pkg::OFFSET_EXT_BITS-1:0] w_off_ext;

    assign w_chr    = i_word.chr;
    assign w_lc     = i_word.chr | CASE_BIT;
    assign w_is_nul = (w_chr == CH_NUL);

    // A terminator can only move on when the result register has room.
    assign o_take     = i_word.valid && (!w_is_nul || i_res_room);
    assign o_res_load = i_word.valid && w_is_nul && i_res_room;

    // Hex digit decode, either case.
    always_comb begin
        w_hex_ok  = 1'b0;
        w_hex_val = 4'd0;
        if (w_chr >= CH_ZERO && w_chr <= CH_NINE) begin
            w_hex_ok  = 1'b1;
            w_hex_val = 4'(w_chr - CH_ZERO);
        end else if (w_lc >= CH_LO_A && w_lc <= CH_LO_F) begin
            w_hex_ok  = 1'b1;
            w_hex_val = 4'(w_lc - CH_LO_A + 8'd10);
        end
    end

    // Base in force for this character's digit test.
    always_comb begin
        if (r_phase == itp_pkg::PH_DIGITS) begin
            w_dig_base = r_base;
        end else if (r_phase == itp_pkg::PH_ZERO) begin
            w_dig_base = (i_cfg.radix != '0) ? i_cfg.radix : BASE_OCT;
        end else begin
            w_dig_base = (i_cfg.radix != '0) ? i_cfg.radix : BASE_DEC;
        end
    end

    // Before the first digit the accumulator is zero, so the leading zero of
    // an octal number needs no extra multiply.
    assign w_dig_ok = w_hex_ok && (itp_pkg::BASE_BITS'(w_hex_val) < w_dig_base);
    assign w_prod   = PROD_BITS'(r_accum) * PROD_BITS'(w_dig_base);
    assign w_mac    = w_prod[VALUE_BITS-1:0] + VALUE_BITS'(w_hex_val);

    assign w_suffix_hit = i_cfg.suffix_enable &&
                          (w_lc == CH_LO_K || w_lc == CH_LO_M || w_lc == CH_LO_G);

    always_comb begin
        if (w_lc == CH_LO_G) begin
            w_shifted = r_accum << SHIFT_G;
        end else if (w_lc == CH_LO_M) begin
            w_shifted = r_accum << SHIFT_M;
        end else begin
            w_shifted = r_accum << SHIFT_K;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= itp_pkg::PH_START;
            r_accum      <= '0;
            r_base       <= '0;
            r_consumed   <= '0;
            r_negate     <= 1'b0;
            r_digit_flag <= 1'b0;
            r_tail_cnt   <= 2'd0;
            r_tail_nl    <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_accum      <= n_accum;
            r_base       <= n_base;
            r_consumed   <= n_consumed;
            r_negate     <= n_negate;
            r_digit_flag <= n_digit_flag;
            r_tail_cnt   <= n_tail_cnt;
            r_tail_nl    <= n_tail_nl;
        end
    end

    // Next-state logic for one character.
    always_comb begin
        n_phase      = r_phase;
        n_accum      = r_accum;
        n_base       = r_base;
        n_negate     = r_negate;
        n_digit_flag = r_digit_flag;
        n_tail_cnt   = r_tail_cnt;
        n_tail_nl    = r_tail_nl;
        w_digit_step = 1'b0;
        w_tail_step  = 1'b0;
        w_take_cnt   = 2'd0;

        if (w_is_nul) begin
            // A lone zero still counts as one consumed digit.
            w_take_cnt = (r_phase == itp_pkg::PH_ZERO) ? 2'd1 : 2'd0;
            if (o_take) begin
                n_phase      = itp_pkg::PH_START;
                n_accum      = '0;
                n_base       = '0;
                n_negate     = 1'b0;
                n_digit_flag = 1'b0;
                n_tail_cnt   = 2'd0;
                n_tail_nl    = 1'b0;
            end
        end else if (o_take) begin
            unique case (r_phase)
                itp_pkg::PH_START, itp_pkg::PH_PREFIX: begin
                    if (r_phase == itp_pkg::PH_START && w_chr == CH_MINUS &&
                        i_cfg.sign_enable) begin
                        n_negate   = 1'b1;
                        w_take_cnt = 2'd1;
                        n_phase    = itp_pkg::PH_PREFIX;
                    end else if (w_chr == CH_ZERO) begin
                        n_phase = itp_pkg::PH_ZERO;
                    end else begin
                        n_base       = w_dig_base;
                        w_digit_step = 1'b1;
                    end
                end
                itp_pkg::PH_ZERO: begin
                    if (w_lc == CH_LO_X) begin
                        n_base     = BASE_HEX;
                        w_take_cnt = 2'd2;
                        n_phase    = itp_pkg::PH_DIGITS;
                    end else begin
                        n_base       = w_dig_base;
                        n_digit_flag = 1'b1;
                        w_take_cnt   = 2'd1;
                        w_digit_step = 1'b1;
                    end
                end
                itp_pkg::PH_DIGITS: begin
                    w_digit_step = 1'b1;
                end
                itp_pkg::PH_SUF_I: begin
                    if (w_chr == CH_LO_I) begin
                        w_take_cnt = 2'd1;
                        n_phase    = itp_pkg::PH_SUF_B;
                    end else if (w_chr == CH_UP_B) begin
                        w_take_cnt = 2'd1;
                        n_phase    = itp_pkg::PH_TAIL;
                    end else begin
                        w_tail_step = 1'b1;
                    end
                end
                itp_pkg::PH_SUF_B: begin
                    if (w_chr == CH_UP_B) begin
                        w_take_cnt = 2'd1;
                        n_phase    = itp_pkg::PH_TAIL;
                    end else begin
                        w_tail_step = 1'b1;
                    end
                end
                default: begin
                    w_tail_step = 1'b1;
                end
            endcase

            if (w_digit_step) begin
                n_phase = itp_pkg::PH_DIGITS;
                if (w_dig_ok) begin
                    n_accum      = w_mac;
                    n_digit_flag = 1'b1;
                    w_take_cnt   = w_take_cnt + 2'd1;
                end else if (w_suffix_hit) begin
                    n_accum    = w_shifted;
                    w_take_cnt = w_take_cnt + 2'd1;
                    n_phase    = itp_pkg::PH_SUF_I;
                end else begin
                    w_tail_step = 1'b1;
                end
            end

            // Trailing characters are only counted, up to two.
            if (w_tail_step) begin
                n_phase = itp_pkg::PH_TAIL;
                if (r_tail_cnt == 2'd0) begin
                    n_tail_nl = (w_chr == CH_NL);
                end
                if (r_tail_cnt != 2'd2) begin
                    n_tail_cnt = r_tail_cnt + 2'd1;
                end
            end
        end
    end

    // Saturating consumed count; a carry out means it passed the maximum.
    assign w_sum          = {1'b0, r_consumed} + SUM_BITS'(w_take_cnt);
    assign w_consumed_sat = w_sum[LEN_BITS] ? '1 : w_sum[LEN_BITS-1:0];

    always_comb begin
        if (!o_take) begin
            n_consumed = r_consumed;
        end else if (w_is_nul) begin
            n_consumed = '0;
        end else begin
            n_consumed = w_consumed_sat;
        end
    end

    assign w_off_ext   = itp_pkg::OFFSET_EXT_BITS'(w_consumed_sat);
    assign o_res_value = r_negate ? (VALUE_BITS'(0) - r_accum) : r_accum;

    assign o_res_meta.end_offset  = w_off_ext[itp_pkg::OFFSET_BITS-1:0];
    assign o_res_meta.strict_ok   = (w_consumed_sat != '0) &&
                                    (r_tail_cnt == 2'd0 || (r_tail_cnt == 2'd1 && r_tail_nl));
    assign o_res_meta.digits_seen = r_digit_flag || (r_phase == itp_pkg::PH_ZERO);

endmodule

### hdl/itp_out_stage.sv
`timescale 1ns / 1ps
// ============================================================================
// Result output register
// Holds one finished result until the downstream side takes it.
// ============================================================================
module itp_out_stage #(
    parameter int VALUE_BITS = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  logic [VALUE_BITS-1:0]  i_value,
    input  itp_pkg::t_result_meta  i_meta,
    output logic                   o_room,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [VALUE_BITS-1:0]  o_value,
    output itp_pkg::t_result_meta  o_meta
);

    logic                  r_valid;
    logic [VALUE_BITS-1:0] r_value;
    itp_pkg::t_result_meta r_meta;

    assign o_room = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_room) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_value <= i_value;
            r_meta  <= i_meta;
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_meta  = r_meta;

endmodule

### hdl/integer_text_parser.sv
`timescale 1ns / 1ps
// ============================================================================
// Integer text parser
// Parses an unsigned or signed integer with optional base prefix and size
// suffix from a NUL-terminated character stream.
// ============================================================================
//
//  Channel   Direction  Word carries                                  Per
//  --------  ---------  --------------------------------------------  ----------
//  i_char    in         char_in (8 bits), NUL ends the string         character
//  o_result  out        value, end_offset, strict_ok, digits_seen     string
//  i_cfg     in         index (0 radix, 1 sign enable, 2 suffix en.)  write
//
// One character word is accepted every cycle when the result side keeps up.
// A character is held in the input register, is folded into the parse
// state by a single multiply-add, and a NUL loads the result register in the
// same cycle. The result word is offered from the result register.
// Reset clears the parse state and sets all configuration registers to zero.
// A NUL waits in the input register while the result register is full and
// not being taken; other characters never stall.
//
module integer_text_parser #(
    parameter int VALUE_BITS = 64,
    parameter int LEN_BITS   = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    itp_char_if.sink             i_char,
    itp_result_if.source         o_result,
    itp_cfg_if.sink              i_cfg
);

    // Configuration registers. Writes are always accepted; an index beyond
    // the register list is ignored.
    itp_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                itp_pkg::CFG_RADIX: begin
                    r_cfg.radix <= i_cfg.data[itp_pkg::BASE_BITS-1:0];
                end
                itp_pkg::CFG_SIGN_ENABLE: begin
                    r_cfg.sign_enable <= i_cfg.data[0];
                end
                itp_pkg::CFG_SUFFIX_ENABLE: begin
                    r_cfg.suffix_enable <= i_cfg.data[0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Datapath between the input register and the result register.
    itp_pkg::t_char_word   w_word;
    logic                  w_take;
    logic                  w_res_load;
    logic                  w_res_room;
    logic [VALUE_BITS-1:0] w_res_value;
    itp_pkg::t_result_meta w_res_meta;
    logic [VALUE_BITS-1:0] w_out_value;
    itp_pkg::t_result_meta w_out_meta;

    itp_char_stage u_char_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_char.valid),
        .i_char  (i_char.char_in),
        .o_ready (i_char.ready),
        .i_take  (w_take),
        .o_word  (w_word)
    );

    itp_parse_core #(
        .VALUE_BITS (VALUE_BITS),
        .LEN_BITS   (LEN_BITS)
    ) u_parse_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_word      (w_word),
        .i_res_room  (w_res_room),
        .o_take      (w_take),
        .o_res_load  (w_res_load),
        .o_res_value (w_res_value),
        .o_res_meta  (w_res_meta)
    );

    itp_out_stage #(
        .VALUE_BITS (VALUE_BITS)
    ) u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_res_load),
        .i_value (w_res_value),
        .i_meta  (w_res_meta),
        .o_room  (w_res_room),
        .o_valid (o_result.valid),
        .i_ready (o_result.ready),
        .o_value (w_out_value),
        .o_meta  (w_out_meta)
    );

    assign o_result.value       = w_out_value;
    assign o_result.end_offset  = w_out_meta.end_offset;
    assign o_result.strict_ok   = w_out_meta.strict_ok;
    assign o_result.digits_seen = w_out_meta.digits_seen;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// Integer text parser testbench
// Sends NUL-terminated strings, one character per word, and checks every
// result word against a cycle-free model of the parser kept alongside. It
// starts with a table of hand-picked strings, then one long string of digits
// and a randomised run under many register settings.
// ============================================================================
module tb_top;

    // Index 3 decodes to no register. Writes to it must leave the settings
    // alone.
    localparam logic [itp_pkg::CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;

    // One parse outcome, laid out as the result word carries it.
    typedef struct packed {
        logic [63:0] value;
        logic [15:0] end_offset;
        logic        strict_ok;
        logic        digits_seen;
    } t_parse;

    // One row of the directed table. Where typed is set, want holds the
    // outcome written out by hand. Otherwise the model supplies it.
    typedef struct {
        logic [4:0] radix;
        bit         sign_en;
        bit         suffix_en;
        string      text;
        bit         typed;
        t_parse     want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    itp_char_if                      char_if ();
    itp_result_if #(.VALUE_BITS(64)) res_if ();
    itp_cfg_if                       cfg_if ();

    integer_text_parser #(
        .VALUE_BITS (64),
        .LEN_BITS   (16)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (char_if),
        .o_result (res_if),
        .i_cfg    (cfg_if)
    );

    // ------------------------------------------------------------------------
    // Directed strings. The first rows run at the reset settings, so they also
    // show that reset left the registers at zero.
    // ------------------------------------------------------------------------
    t_dir_row dir_rows [23] = '{
        // Empty string: nothing consumed, nothing valid.
        '{5'd0,  1'b0, 1'b0, "",                     1'b1, '0},
        // A lone zero is an octal zero.
        '{5'd0,  1'b0, 1'b0, "0",                    1'b1, '{64'd0, 16'd1, 1'b1, 1'b1}},
        // Largest value, then one past it, which wraps round to zero.
        '{5'd0,  1'b0, 1'b0, "18446744073709551615", 1'b1,
          '{64'hFFFF_FFFF_FFFF_FFFF, 16'd20, 1'b1, 1'b1}},
        '{5'd0,  1'b0, 1'b0, "18446744073709551616", 1'b1, '{64'd0, 16'd20, 1'b1, 1'b1}},
        // Hex prefix with no digits after it.
        '{5'd0,  1'b0, 1'b0, "0x",                   1'b1, '{64'd0, 16'd2, 1'b1, 1'b0}},
        '{5'd0,  1'b0, 1'b0, "0XffffFFFFffffFFFF",   1'b1,
          '{64'hFFFF_FFFF_FFFF_FFFF, 16'd18, 1'b1, 1'b1}},
        '{5'd0,  1'b0, 1'b0, "017",                  1'b1, '{64'd15, 16'd3, 1'b1, 1'b1}},
        '{5'd0,  1'b0, 1'b0, "09",                   1'b0, '0},
        // A single trailing newline is still strict, a second one is not.
        '{5'd0,  1'b0, 1'b0, "42\n",                 1'b0, '0},
        '{5'd0,  1'b0, 1'b0, "42\n\n",               1'b0, '0},
        // Minus with the sign disabled is just a stray character.
        '{5'd0,  1'b0, 1'b0, "-5",                   1'b0, '0},
        // Minus on its own.
        '{5'd0,  1'b1, 1'b0, "-",                    1'b1, '{64'd0, 16'd1, 1'b1, 1'b0}},
        '{5'd0,  1'b1, 1'b0, "-1",                   1'b1,
          '{64'hFFFF_FFFF_FFFF_FFFF, 16'd2, 1'b1, 1'b1}},
        // The hex prefix overrides a fixed radix.
        '{5'd10, 1'b1, 1'b0, "-0x10",                1'b0, '0},
        '{5'd0,  1'b0, 1'b1, "1k",                   1'b1, '{64'd1024, 16'd2, 1'b1, 1'b1}},
        '{5'd0,  1'b0, 1'b1, "3MiB",                 1'b0, '0},
        '{5'd0,  1'b0, 1'b1, "2gib",                 1'b0, '0},
        // A suffix with no digits in front of it.
        '{5'd0,  1'b0, 1'b1, "K",                    1'b1, '{64'd0, 16'd1, 1'b1, 1'b0}},
        '{5'd0,  1'b0, 1'b1, "0xffffffffffffffffG",  1'b0, '0},
        // Radix 1 accepts only zeros. Radix 31 still knows only hex digits.
        '{5'd1,  1'b0, 1'b0, "0001",                 1'b0, '0},
        '{5'd31, 1'b0, 1'b0, "fz",                   1'b0, '0},
        '{5'd16, 1'b0, 1'b0, "ABCdef",               1'b0, '0},
        '{5'd2,  1'b0, 1'b0, "0x1",                  1'b0, '0}
    };

    // ------------------------------------------------------------------------
    // Parser model state and settings, updated as each word is accepted
    // ------------------------------------------------------------------------
    logic [4:0]  cfg_radix;
    logic        cfg_sign;
    logic        cfg_suffix;

    itp_pkg::t_phase parse_phase;
    logic [63:0] acc;
    logic [4:0]  num_base;
    logic [15:0] used_len;
    logic        neg;
    logic        got_digit;
    logic [1:0]  tail_len;
    logic        tail_newline;

    // Outcomes of strings whose NUL has gone in but whose result has not
    // yet come back, oldest first.
    t_parse      awaited[$];
    t_parse      oldest;

    bit          steady;
    int          fails;
    int          chars_sent;
    int          strings_sent;
    int          results_seen;
    int          strict_seen;
    int          settings_used;

    function automatic logic [5:0] digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return 6'(c - "0");
        if (c >= "a" && c <= "f") return 6'(c - "a" + 10);
        if (c >= "A" && c <= "F") return 6'(c - "A" + 10);
        return 6'd32;
    endfunction

    function void count_used();
        if (used_len != 16'hFFFF) used_len++;
    endfunction

    // Anything after the parsed part only matters for the strict flag: how
    // many characters there were (up to two), and whether the first was a
    // newline.
    function void note_tail(input logic [7:0] c);
        parse_phase = itp_pkg::PH_TAIL;
        if (tail_len == 2'd0) tail_newline = (c == 8'h0A);
        if (tail_len < 2'd2) tail_len++;
    endfunction

    function void take_digit(input logic [7:0] c);
        logic [5:0] d;
        logic [7:0] lc;
        d  = digit_value(c);
        lc = c | 8'h20;
        if (d < {1'b0, num_base}) begin
            acc       = acc * {59'd0, num_base} + {58'd0, d};
            got_digit = 1'b1;
            count_used();
        end else if (cfg_suffix && (lc == "k" || lc == "m" || lc == "g")) begin
            if (lc == "g")      acc = acc << 30;
            else if (lc == "m") acc = acc << 20;
            else                acc = acc << 10;
            count_used();
            parse_phase = itp_pkg::PH_SUF_I;
        end else begin
            note_tail(c);
        end
    endfunction

    function void take_first(input logic [7:0] c);
        if (c == "0") begin
            parse_phase = itp_pkg::PH_ZERO;
        end else begin
            num_base    = (cfg_radix != 5'd0) ? cfg_radix : 5'd10;
            parse_phase = itp_pkg::PH_DIGITS;
            take_digit(c);
        end
    endfunction

    // A leading zero was seen: either the hex prefix follows, or the zero
    // was the first digit of an octal (or fixed-radix) number.
    function void after_zero(input logic [7:0] c);
        if ((c | 8'h20) == "x") begin
            num_base = 5'd16;
            count_used();
            count_used();
            parse_phase = itp_pkg::PH_DIGITS;
        end else begin
            num_base    = (cfg_radix != 5'd0) ? cfg_radix : 5'd8;
            parse_phase = itp_pkg::PH_DIGITS;
            take_digit("0");
            take_digit(c);
        end
    endfunction

    function void take_b(input logic [7:0] c);
        if (c == "B") begin
            count_used();
            parse_phase = itp_pkg::PH_TAIL;
        end else begin
            note_tail(c);
        end
    endfunction

    function void clear_parse();
        parse_phase  = itp_pkg::PH_START;
        acc          = '0;
        num_base     = '0;
        used_len     = '0;
        neg          = 1'b0;
        got_digit    = 1'b0;
        tail_len     = '0;
        tail_newline = 1'b0;
    endfunction

    // Folds one accepted character into the model. A NUL closes the string
    // and queues the outcome it should produce.
    function void parse_char(input logic [7:0] c);
        t_parse r;
        if (c != 8'h00) begin
            case (parse_phase)
                itp_pkg::PH_START: begin
                    if (c == "-" && cfg_sign) begin
                        neg = 1'b1;
                        count_used();
                        parse_phase = itp_pkg::PH_PREFIX;
                    end else begin
                        take_first(c);
                    end
                end
                itp_pkg::PH_PREFIX: take_first(c);
                itp_pkg::PH_ZERO:   after_zero(c);
                itp_pkg::PH_DIGITS: take_digit(c);
                itp_pkg::PH_SUF_I: begin
                    if (c == "i") begin
                        count_used();
                        parse_phase = itp_pkg::PH_SUF_B;
                    end else begin
                        take_b(c);
                    end
                end
                itp_pkg::PH_SUF_B:  take_b(c);
                default:            note_tail(c);
            endcase
        end else begin
            // A string that ends right after its leading zero is octal zero.
            if (parse_phase == itp_pkg::PH_ZERO) begin
                num_base    = (cfg_radix != 5'd0) ? cfg_radix : 5'd8;
                parse_phase = itp_pkg::PH_DIGITS;
                take_digit("0");
            end
            r.value       = neg ? -acc : acc;
            r.end_offset  = used_len;
            r.strict_ok   = (used_len != 16'd0) &&
                            (tail_len == 2'd0 || (tail_len == 2'd1 && tail_newline));
            r.digits_seen = got_digit;
            awaited.push_back(r);
            clear_parse();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Character side
    // ------------------------------------------------------------------------

    // Offers one character word and returns at the edge that takes it. Now
    // and then the line goes quiet first, unless a steady stretch is
    // running.
    task automatic send_char(input logic [7:0] c);
        if (!steady && $urandom_range(99) < 6) begin
            char_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        char_if.valid   <= 1'b1;
        char_if.char_in <= c;
        do @(posedge i_clk); while (!char_if.ready);
        chars_sent++;
        parse_char(c);
    endtask

    task automatic send_text(input string t);
        for (int k = 0; k < t.len(); k++) send_char(t[k]);
        send_char(8'h00);
        strings_sent++;
    endtask

    // Waits until every queued outcome has been matched, then lets the line
    // idle before returning.
    task automatic drain();
        char_if.valid <= 1'b0;
        while (awaited.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Configuration side
    // ------------------------------------------------------------------------
    task automatic cfg_write(input logic [itp_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [itp_pkg::CFG_DATA_BITS-1:0] dat);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= dat;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            itp_pkg::CFG_RADIX:         cfg_radix  = dat[4:0];
            itp_pkg::CFG_SIGN_ENABLE:   cfg_sign   = dat[0];
            itp_pkg::CFG_SUFFIX_ENABLE: cfg_suffix = dat[0];
            default: ;
        endcase
    endtask

    // Writes all three registers back to back, holding valid high in
    // between, and optionally a stray write to the spare index first.
    task automatic write_config(input logic [7:0] radix_d, input logic [7:0] sign_d,
                                input logic [7:0] suffix_d, input bit stray);
        if (stray) cfg_write(CFG_SPARE, 8'($urandom));
        cfg_write(itp_pkg::CFG_RADIX, radix_d);
        cfg_write(itp_pkg::CFG_SIGN_ENABLE, sign_d);
        cfg_write(itp_pkg::CFG_SUFFIX_ENABLE, suffix_d);
        cfg_if.valid <= 1'b0;
        settings_used++;
    endtask

    // Picks a new setting, leaning on the extremes of the radix. The unused
    // upper data bits are random, as the registers should ignore them.
    task automatic random_config();
        logic [4:0] r;
        case ($urandom_range(7))
            0:       r = 5'd0;
            1:       r = 5'd1;
            2:       r = 5'd16;
            3:       r = 5'd31;
            4:       r = 5'd10;
            5:       r = 5'd8;
            default: r = 5'($urandom_range(31));
        endcase
        drain();
        write_config({3'($urandom), r}, 8'($urandom), 8'($urandom),
                     $urandom_range(3) == 0);
    endtask

    // ------------------------------------------------------------------------
    // Random strings
    // ------------------------------------------------------------------------
    function automatic logic [7:0] digit_char(input int v);
        if (v < 10) return 8'("0" + v);
        return 8'(($urandom_range(1) ? "a" : "A") + v - 10);
    endfunction

    // Most strings are well-formed numbers with random content: sign,
    // prefix, digits mostly valid for the base, a size suffix, and a tail.
    // One in ten is pure noise and one in ten has a stray byte dropped in.
    task automatic send_random_string();
        logic [7:0] s[$];
        int         kind;
        int         pick;
        int         ndig;
        int         base_guess;
        int         v;
        bit         hex_pfx;
        bit         zero_pfx;
        kind = $urandom_range(99);
        if (kind < 10) begin
            repeat ($urandom_range(0, 8)) s.push_back(8'($urandom_range(1, 255)));
        end else begin
            if ($urandom_range(3) == 0) s.push_back("-");
            pick     = $urandom_range(5);
            hex_pfx  = (pick == 0);
            zero_pfx = (pick == 1);
            if (hex_pfx) begin
                s.push_back("0");
                s.push_back($urandom_range(1) ? "x" : "X");
            end else if (zero_pfx) begin
                s.push_back("0");
            end
            base_guess = hex_pfx ? 16 : (cfg_radix != 5'd0) ? int'(cfg_radix) :
                         zero_pfx ? 8 : 10;
            if (base_guess > 16) base_guess = 16;
            ndig = ($urandom_range(9) == 0) ? $urandom_range(15, 24) : $urandom_range(0, 8);
            repeat (ndig) begin
                v = ($urandom_range(9) == 0) ? $urandom_range(15) :
                    $urandom_range(base_guess - 1);
                s.push_back(digit_char(v));
            end
            if ($urandom_range(2) == 0) begin
                case ($urandom_range(5))
                    0:       s.push_back("k");
                    1:       s.push_back("K");
                    2:       s.push_back("m");
                    3:       s.push_back("M");
                    4:       s.push_back("g");
                    default: s.push_back("G");
                endcase
                if ($urandom_range(1)) s.push_back(($urandom_range(7) == 0) ? "I" : "i");
                if ($urandom_range(1)) s.push_back(($urandom_range(7) == 0) ? "b" : "B");
            end
            case ($urandom_range(5))
                0: s.push_back(8'h0A);
                1: begin
                    s.push_back(8'h0A);
                    s.push_back(8'($urandom_range(1, 255)));
                end
                2: repeat ($urandom_range(1, 3)) s.push_back(8'($urandom_range(1, 255)));
                default: ;
            endcase
            if (kind >= 90) s.insert($urandom_range(s.size()), 8'($urandom_range(1, 255)));
        end
        foreach (s[i]) send_char(s[i]);
        send_char(8'h00);
        strings_sent++;
    endtask

    // ------------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Ends a run that hangs with an error.
    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: the receiver stalls at random, and every result word taken
    // is checked against the oldest queued outcome.
    // ------------------------------------------------------------------------
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                if (awaited.size() == 0) begin
                    $error("result word with no string pending: value %h", res_if.value);
                    fails++;
                end else begin
                    oldest = awaited.pop_front();
                    results_seen++;
                    if (res_if.strict_ok) strict_seen++;
                    if (res_if.value !== oldest.value) begin
                        $error("value: expected %h, got %h", oldest.value, res_if.value);
                        fails++;
                    end
                    if (res_if.end_offset !== oldest.end_offset) begin
                        $error("end_offset: expected %0d, got %0d",
                               oldest.end_offset, res_if.end_offset);
                        fails++;
                    end
                    if (res_if.strict_ok !== oldest.strict_ok) begin
                        $error("strict_ok: expected %b, got %b",
                               oldest.strict_ok, res_if.strict_ok);
                        fails++;
                    end
                    if (res_if.digits_seen !== oldest.digits_seen) begin
                        $error("digits_seen: expected %b, got %b",
                               oldest.digits_seen, res_if.digits_seen);
                        fails++;
                    end
                end
            end
            res_if.ready <= steady || ($urandom_range(99) >= 6);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int phase_left;
        int wait_cycles;

        char_if.valid   = 1'b0;
        char_if.char_in = 8'h00;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = itp_pkg::CFG_RADIX;
        cfg_if.data     = 8'h00;
        i_rst_n         = 1'b0;
        steady          = 1'b0;
        fails           = 0;
        chars_sent      = 0;
        strings_sent    = 0;
        results_seen    = 0;
        strict_seen     = 0;
        settings_used   = 1;
        cfg_radix       = 5'd0;
        cfg_sign        = 1'b0;
        cfg_suffix      = 1'b0;
        clear_parse();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. Registers change only between strings, after the
        // block has gone quiet.
        foreach (dir_rows[i]) begin
            if (dir_rows[i].radix != cfg_radix || dir_rows[i].sign_en != cfg_sign ||
                dir_rows[i].suffix_en != cfg_suffix) begin
                drain();
                write_config({3'd0, dir_rows[i].radix}, {7'd0, dir_rows[i].sign_en},
                             {7'd0, dir_rows[i].suffix_en}, 1'b0);
            end
            send_text(dir_rows[i].text);
            if (dir_rows[i].typed) awaited[awaited.size() - 1] = dir_rows[i].want;
        end

        // One long string of digits, far past the 64-bit range.
        drain();
        write_config(8'd0, 8'd0, 8'd0, 1'b0);
        repeat (200) send_char("1");
        send_char(8'h00);
        strings_sent++;

        // Random run, with the settings changed every few strings. A run of
        // strings in the middle goes with no random idling on either side.
        phase_left = 0;
        while (chars_sent < 1650) begin
            if (phase_left == 0) begin
                random_config();
                phase_left = $urandom_range(8, 24);
            end
            steady = (strings_sent >= 80 && strings_sent < 120);
            send_random_string();
            phase_left--;
        end
        steady = 1'b0;

        // Let the last results come home, within a limit.
        char_if.valid <= 1'b0;
        wait_cycles = 0;
        while (awaited.size() != 0 && wait_cycles < 5000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (8) @(posedge i_clk);
        while (awaited.size() != 0) begin
            oldest = awaited.pop_front();
            $error("no result for string: expected value %h, end_offset %0d",
                   oldest.value, oldest.end_offset);
            fails++;
        end

        $display("Ran %0d strings (%0d characters) under %0d register settings.",
                 strings_sent, chars_sent, settings_used);
        $display("Checked %0d result words, %0d of them strict.", results_seen, strict_seen);
        if (fails == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
